FILE: hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int NEED_W  = 9;
  localparam int OWNER_W = 8;
  localparam int IDX_W   = 8;
  localparam int LEN_W   = 9;
  localparam int COUNT_W = 9;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  // one page table entry as stored in the page ram
  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic               alloc;
    logic [LEN_W-1:0]   len;
  } page_word_t;

  localparam int WORD_W = $bits(page_word_t);

  typedef struct packed {
    logic              kind;
    logic [NEED_W-1:0] pages_needed;
    logic [OWNER_W-1:0] owner;
    logic [IDX_W-1:0]  page_index;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   head_index;
    logic [COUNT_W-1:0] pages_freed;
    logic [COUNT_W-1:0] free_pages;
  } res_t;

endpackage

FILE: hdl/cpa_if.sv
// ----------------------------------------------------------------------------
// cpa_if
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface cpa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [cpa_pkg::NEED_W-1:0] pages_needed;
  logic [cpa_pkg::OWNER_W-1:0] owner;
  logic [cpa_pkg::IDX_W-1:0]  page_index;

  modport source (output valid, output kind, output pages_needed, output owner,
                  output page_index, input ready);
  modport sink (input valid, input kind, input pages_needed, input owner,
                input page_index, output ready);
endinterface

interface cpa_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [cpa_pkg::IDX_W-1:0]   head_index;
  logic [cpa_pkg::COUNT_W-1:0] pages_freed;
  logic [cpa_pkg::COUNT_W-1:0] free_pages;

  modport source (output valid, output status, output head_index,
                  output pages_freed, output free_pages, input ready);
  modport sink (input valid, input status, input head_index,
                input pages_freed, input free_pages, output ready);
endinterface

FILE: hdl/cpa_ram.sv
// ----------------------------------------------------------------------------
// cpa_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module cpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cpa_engine.sv
// ----------------------------------------------------------------------------
// cpa_engine
// Sequencer that walks the page ram one entry per cycle for clear, first-fit
// search, run marking and run release.
// ----------------------------------------------------------------------------
module cpa_engine #(
  parameter int NUM_PAGES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpa_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_take,
  output cpa_pkg::res_t  res
);

  localparam int AW = NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1;
  localparam int FW = $clog2(NUM_PAGES + 1);
  localparam int CW = FW > cpa_pkg::NEED_W ? FW : cpa_pkg::NEED_W;
  localparam logic [AW:0]   LAST_W = (AW + 1)'(NUM_PAGES - 1);
  localparam logic [AW-1:0] LAST_A = AW'(NUM_PAGES - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MARK = 3'd3;
  localparam logic [2:0] S_FREE = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [AW:0]                 cnt_r, cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pidx_r, pidx_nxt;
  logic [cpa_pkg::NEED_W-1:0]  need_r, need_nxt;
  logic [cpa_pkg::OWNER_W-1:0] owner_r, owner_nxt;
  logic [cpa_pkg::NEED_W-1:0]  left_r, left_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [AW-1:0]               mk_r, mk_nxt;
  logic [cpa_pkg::NEED_W-1:0]  mleft_r, mleft_nxt;
  logic [cpa_pkg::LEN_W-1:0]   off_r, off_nxt;
  logic [cpa_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                        first_r, first_nxt;
  logic [FW-1:0]               freed_r, freed_nxt;
  logic [FW-1:0]               fcnt_r, fcnt_nxt;
  cpa_pkg::res_t               res_r, res_nxt;

  logic                        we;
  logic [AW-1:0]               waddr;
  cpa_pkg::page_word_t         wword;
  cpa_pkg::page_word_t         rword;
  logic [cpa_pkg::WORD_W-1:0]  rdata;
  logic                        issue;
  logic [cpa_pkg::LEN_W-1:0]   len_eff;
  logic [FW-1:0]               freed_sum;
  logic [FW-1:0]               fcnt_sub;
  logic [FW-1:0]               fcnt_add;

  cpa_ram #(
    .WIDTH (cpa_pkg::WORD_W),
    .DEPTH (NUM_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wword),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rdata)
  );

  assign rword     = rdata;
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;
  assign issue     = (cnt_r <= LAST_W);
  assign len_eff   = first_r ? rword.len : len_r;
  assign freed_sum = freed_r + FW'(rword.alloc);
  assign fcnt_sub  = fcnt_r - FW'(need_r);
  assign fcnt_add  = fcnt_r + freed_sum;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = cnt_r[AW-1:0];
    need_nxt  = need_r;
    owner_nxt = owner_r;
    left_nxt  = left_r;
    head_nxt  = head_r;
    mk_nxt    = mk_r;
    mleft_nxt = mleft_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    freed_nxt = freed_r;
    fcnt_nxt  = fcnt_r;
    res_nxt   = res_r;
    we        = 1'b0;
    waddr     = cnt_r[AW-1:0];
    wword     = '{owner: '0, alloc: 1'b0, len: cpa_pkg::LEN_W'(1)};

    unique case (state_r)
      S_CLR: begin
        // reset sweep: every page free with length one
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_W) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          need_nxt  = req.pages_needed;
          owner_nxt = req.owner;
          if (req.kind == cpa_pkg::KIND_ALLOC) begin
            if (req.pages_needed == '0 || CW'(fcnt_r) < CW'(req.pages_needed)) begin
              res_nxt   = '{status: cpa_pkg::STATUS_NO_SPACE, head_index: '0,
                            pages_freed: '0, free_pages: cpa_pkg::COUNT_W'(fcnt_r)};
              state_nxt = S_RESP;
            end else begin
              cnt_nxt   = '0;
              left_nxt  = req.pages_needed;
              head_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (int'(req.page_index) >= NUM_PAGES) begin
              res_nxt   = '{status: cpa_pkg::STATUS_DONE, head_index: '0,
                            pages_freed: '0, free_pages: cpa_pkg::COUNT_W'(fcnt_r)};
              state_nxt = S_RESP;
            end else begin
              cnt_nxt   = (AW + 1)'(req.page_index);
              first_nxt = 1'b1;
              off_nxt   = '0;
              freed_nxt = '0;
              state_nxt = S_FREE;
            end
          end
        end
      end

      S_SCAN: begin
        if (issue) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (rword.alloc) begin
            left_nxt = need_r;
            head_nxt = pidx_r + 1'b1;
          end else begin
            left_nxt = left_r - 1'b1;
          end
          if (!rword.alloc && left_r == cpa_pkg::NEED_W'(1)) begin
            mk_nxt    = head_r;
            mleft_nxt = need_r;
            pend_nxt  = 1'b0;
            state_nxt = S_MARK;
          end else if (pidx_r == LAST_A) begin
            res_nxt   = '{status: cpa_pkg::STATUS_NO_SPACE, head_index: '0,
                          pages_freed: '0, free_pages: cpa_pkg::COUNT_W'(fcnt_r)};
            pend_nxt  = 1'b0;
            state_nxt = S_RESP;
          end
        end
      end

      S_MARK: begin
        we        = 1'b1;
        waddr     = mk_r;
        wword     = '{owner: owner_r, alloc: 1'b1,
                      len: (mk_r == head_r) ? need_r : cpa_pkg::LEN_W'(1)};
        mk_nxt    = mk_r + 1'b1;
        mleft_nxt = mleft_r - 1'b1;
        if (mleft_r == cpa_pkg::NEED_W'(1)) begin
          fcnt_nxt  = fcnt_sub;
          res_nxt   = '{status: cpa_pkg::STATUS_DONE,
                        head_index: cpa_pkg::IDX_W'(head_r),
                        pages_freed: '0, free_pages: cpa_pkg::COUNT_W'(fcnt_sub)};
          state_nxt = S_RESP;
        end
      end

      S_FREE: begin
        if (issue) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          // head entry gives the run length, later entries just get cleared
          len_nxt   = len_eff;
          first_nxt = 1'b0;
          we        = 1'b1;
          waddr     = pidx_r;
          wword     = '{owner: rword.owner, alloc: 1'b0, len: cpa_pkg::LEN_W'(1)};
          freed_nxt = freed_sum;
          off_nxt   = off_r + 1'b1;
          if (off_r + 1'b1 == len_eff || pidx_r == LAST_A) begin
            fcnt_nxt  = fcnt_add;
            res_nxt   = '{status: cpa_pkg::STATUS_DONE, head_index: '0,
                          pages_freed: cpa_pkg::COUNT_W'(freed_sum),
                          free_pages: cpa_pkg::COUNT_W'(fcnt_add)};
            pend_nxt  = 1'b0;
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      fcnt_r  <= FW'(NUM_PAGES);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    need_r  <= need_nxt;
    owner_r <= owner_nxt;
    left_r  <= left_nxt;
    head_r  <= head_nxt;
    mk_r    <= mk_nxt;
    mleft_r <= mleft_nxt;
    off_r   <= off_nxt;
    len_r   <= len_nxt;
    first_r <= first_nxt;
    freed_r <= freed_nxt;
    res_r   <= res_nxt;
  end

endmodule

FILE: hdl/contiguous_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator_unit
// First-fit contiguous page allocator with an output result register.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  in_ch    | in  | valid / ready  | kind, pages_needed, owner, page_index
//  out_ch   | out | valid / ready  | status, head_index, pages_freed, free_pages
//
//  allocate: accept, a scan of one page ram entry per cycle, marking of
//  pages_needed entries and a result
//  free: clears the run; refused or out-of-range requests go to the result
//  after reset a clearing pass over all NUM_PAGES entries holds in_ch.ready low
//  a result waits in the output register; the engine stalls only if a second
//  result is ready while the first has not been taken
// ----------------------------------------------------------------------------
module contiguous_page_allocator_unit #(
  parameter int NUM_PAGES = 256
) (
  input logic        clk,
  input logic        rst_n,
  cpa_in_if.sink     in_ch,
  cpa_out_if.source  out_ch
);

  cpa_pkg::req_t req;
  cpa_pkg::res_t res;
  cpa_pkg::res_t out_res_r;
  logic          out_valid_r, out_valid_nxt;
  logic          res_valid;
  logic          res_take;
  logic          res_load;

  assign req = '{kind: in_ch.kind, pages_needed: in_ch.pages_needed,
                 owner: in_ch.owner, page_index: in_ch.page_index};

  cpa_engine #(
    .NUM_PAGES (NUM_PAGES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output slot is free when empty or being drained this cycle
  assign res_take = !out_valid_r || out_ch.ready;
  assign res_load = res_valid && res_take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.head_index  = out_res_r.head_index;
  assign out_ch.pages_freed = out_res_r.pages_freed;
  assign out_ch.free_pages  = out_res_r.free_pages;

endmodule

FILE: hdl/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cpa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_status,
  input logic [cpa_pkg::IDX_W-1:0]   out_head_index,
  input logic [cpa_pkg::COUNT_W-1:0] out_pages_freed,
  input logic [cpa_pkg::COUNT_W-1:0] out_free_pages
);

  // the engine is busy right after it takes a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready still high after accepted transaction");

  a_no_space_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cpa_pkg::STATUS_NO_SPACE |->
      out_head_index == '0 && out_pages_freed == '0)
    else $error("no_space result carries head or freed pages");

  a_freed_only_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pages_freed != '0 |->
      out_status == cpa_pkg::STATUS_DONE && out_head_index == '0)
    else $error("freed pages reported with allocate fields");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_head_index) && $stable(out_pages_freed) && $stable(out_free_pages))
    else $error("stalled result changed");

endmodule

bind contiguous_page_allocator_unit cpa_checker u_cpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_head_index  (out_ch.head_index),
  .out_pages_freed (out_ch.pages_freed),
  .out_free_pages  (out_ch.free_pages)
);
